>>> rtl/core/rtoq_pkg.sv
// shared types, sizes and the overlap test for the rectangle table query block
package rtoq_pkg;

    localparam int OBSTACLE_DEPTH = 16;
    localparam int TARGET_DEPTH   = 16;
    localparam int COORD_BITS     = 16;

    localparam int MAX_DEPTH = (OBSTACLE_DEPTH > TARGET_DEPTH) ? OBSTACLE_DEPTH : TARGET_DEPTH;
    localparam int OBS_AW    = (OBSTACLE_DEPTH > 1) ? $clog2(OBSTACLE_DEPTH) : 1;
    localparam int TGT_AW    = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
    localparam int OBS_CW    = $clog2(OBSTACLE_DEPTH + 1);
    localparam int TGT_CW    = $clog2(TARGET_DEPTH + 1);
    localparam int IDX_W     = $clog2(MAX_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ADD_OBSTACLE = 2'd0,
        CMD_ADD_TARGET   = 2'd1,
        CMD_CLEAR        = 2'd2,
        CMD_QUERY        = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_QUERY
    } state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
    } req_t;

    typedef struct packed {
        logic hit_obstacle;
        logic hit_target;
        logic status;
    } rsp_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-2:0]        size_t;
    typedef logic signed [COORD_BITS:0]   sum_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        size_t  w;
        size_t  h;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

    // take the low coordinate bits of the request and sign-extend from the top one
    function automatic rect_t rect_of(req_t r);
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ew;
        logic [31:0] eh;
        rect_t       o;
        ex  = 32'(r.pos_x);
        ey  = 32'(r.pos_y);
        ew  = 32'(r.rect_width);
        eh  = 32'(r.rect_height);
        o.x = ex[COORD_BITS-1:0];
        o.y = ey[COORD_BITS-1:0];
        o.w = ew[COORD_BITS-2:0];
        o.h = eh[COORD_BITS-2:0];
        return o;
    endfunction

    function automatic sum_t right_of(rect_t r);
        return sum_t'(r.x) + sum_t'(r.w);
    endfunction

    function automatic sum_t bottom_of(rect_t r);
        return sum_t'(r.y) + sum_t'(r.h);
    endfunction

    // strict overlap, shared edges do not count
    function automatic logic overlap(rect_t a, rect_t b, sum_t b_right, sum_t b_bottom);
        return (bottom_of(a) > sum_t'(b.y)) && (sum_t'(a.y) < b_bottom) &&
               (right_of(a) > sum_t'(b.x)) && (sum_t'(a.x) < b_right);
    endfunction

endpackage

>>> rtl/core/rtoq_ram.sv
// generic single-port-write, registered-read ram
module rtoq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/rect_table_overlap_query.sv
// rectangle table query: two rectangle tables with append, clear and overlap query
//
// start/req carry one command beat, taken at a clock edge where start is high and busy
// is low. every beat yields exactly one result on rsp, marked by done for one cycle;
// the receiver cannot hold results off, and the output register lets a new command
// be taken in the same cycle that done is shown.
// append and clear: done comes in the cycle after the beat, busy stays low, so these
// commands can be issued back to back.
// query: both tables sit in registered-read rams and are scanned in parallel, one
// entry of each per cycle. busy is high while max(obstacle count, target count, 1)
// entries are read, and done comes in the same cycle that busy falls.
// the ram read port is what sets this pace. busy also keeps an append from writing
// an entry while a scan is still reading.
// an append to a full table is dropped and reported with status set.
// reset clears both counts and the control state; the table contents are left as
// they are, since only entries below the count are ever used.
module rect_table_overlap_query
    import rtoq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    state_t             state_reg, state_next;
    logic [OBS_CW-1:0]  obs_cnt_reg, obs_cnt_next;
    logic [TGT_CW-1:0]  tgt_cnt_reg, tgt_cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               hit_o_reg, hit_o_next;
    logic               hit_t_reg, hit_t_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;
    rect_t              q_reg, q_next;
    sum_t               q_right_reg, q_right_next;
    sum_t               q_bottom_reg, q_bottom_next;

    rect_t              in_rect;
    logic               accept;
    logic               obs_we, tgt_we, rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   idx_inc;
    logic               obs_valid, tgt_valid, scan_last;
    logic               obs_hit, tgt_hit;
    logic [RECT_W-1:0]  obs_rdata, tgt_rdata;

    assign in_rect   = rect_of(req);
    assign accept    = start && (state_reg == ST_IDLE);
    assign idx_inc   = idx_reg + IDX_W'(1);
    assign obs_valid = IDX_W'(obs_cnt_reg) > idx_reg;
    assign tgt_valid = IDX_W'(tgt_cnt_reg) > idx_reg;
    assign scan_last = (idx_inc >= IDX_W'(obs_cnt_reg)) && (idx_inc >= IDX_W'(tgt_cnt_reg));
    assign obs_hit   = obs_valid && overlap(rect_t'(obs_rdata), q_reg, q_right_reg, q_bottom_reg);
    assign tgt_hit   = tgt_valid && overlap(rect_t'(tgt_rdata), q_reg, q_right_reg, q_bottom_reg);

    rtoq_ram #(
        .WIDTH (RECT_W),
        .DEPTH (OBSTACLE_DEPTH)
    ) u_obs_ram (
        .clk   (clk),
        .we    (obs_we),
        .waddr (obs_cnt_reg[OBS_AW-1:0]),
        .wdata (in_rect),
        .re    (rd_en),
        .raddr (OBS_AW'(rd_idx)),
        .rdata (obs_rdata)
    );

    rtoq_ram #(
        .WIDTH (RECT_W),
        .DEPTH (TARGET_DEPTH)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_cnt_reg[TGT_AW-1:0]),
        .wdata (in_rect),
        .re    (rd_en),
        .raddr (TGT_AW'(rd_idx)),
        .rdata (tgt_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.cmd == CMD_QUERY)
                begin
                    state_next = ST_QUERY;
                end
            end
            ST_QUERY:
            begin
                if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        obs_cnt_next  = obs_cnt_reg;
        tgt_cnt_next  = tgt_cnt_reg;
        idx_next      = idx_reg;
        hit_o_next    = hit_o_reg;
        hit_t_next    = hit_t_reg;
        q_next        = q_reg;
        q_right_next  = q_right_reg;
        q_bottom_next = q_bottom_reg;
        rsp_next      = rsp_reg;
        done_next     = 1'b0;
        obs_we        = 1'b0;
        tgt_we        = 1'b0;
        rd_en         = 1'b0;
        rd_idx        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next = '0;
                    unique case (req.cmd)
                        CMD_ADD_OBSTACLE:
                        begin
                            done_next = 1'b1;
                            if (obs_cnt_reg == OBS_CW'(OBSTACLE_DEPTH))
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else
                            begin
                                obs_we       = 1'b1;
                                obs_cnt_next = obs_cnt_reg + OBS_CW'(1);
                            end
                        end
                        CMD_ADD_TARGET:
                        begin
                            done_next = 1'b1;
                            if (tgt_cnt_reg == TGT_CW'(TARGET_DEPTH))
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else
                            begin
                                tgt_we       = 1'b1;
                                tgt_cnt_next = tgt_cnt_reg + TGT_CW'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            done_next    = 1'b1;
                            obs_cnt_next = '0;
                            tgt_cnt_next = '0;
                        end
                        CMD_QUERY:
                        begin
                            // first read goes out with the command beat
                            rd_en         = 1'b1;
                            rd_idx        = '0;
                            idx_next      = '0;
                            hit_o_next    = 1'b0;
                            hit_t_next    = 1'b0;
                            q_next        = in_rect;
                            q_right_next  = right_of(in_rect);
                            q_bottom_next = bottom_of(in_rect);
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_QUERY:
            begin
                hit_o_next = hit_o_reg | obs_hit;
                hit_t_next = hit_t_reg | tgt_hit;
                if (scan_last)
                begin
                    done_next             = 1'b1;
                    rsp_next.hit_obstacle = hit_o_reg | obs_hit;
                    rsp_next.hit_target   = hit_t_reg | tgt_hit;
                    rsp_next.status       = 1'b0;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_inc;
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            obs_cnt_reg <= '0;
            tgt_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            obs_cnt_reg <= obs_cnt_next;
            tgt_cnt_reg <= tgt_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        hit_o_reg    <= hit_o_next;
        hit_t_reg    <= hit_t_next;
        q_reg        <= q_next;
        q_right_reg  <= q_right_next;
        q_bottom_reg <= q_bottom_next;
        rsp_reg      <= rsp_next;
    end

    assign busy = (state_reg == ST_QUERY);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> rtl/core/rtoq_checker.sv
// port-level checks for the rectangle table query block, bound to the top level
module rtoq_checker
    import rtoq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input req_t req,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // a result beat never coincides with a running scan
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // appends and clears answer in the next cycle
    a_short_cmd_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd != CMD_QUERY) |=> (done && !busy))
        else $error("append or clear without result beat");

    // a query always starts a scan and gives no result right away
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd == CMD_QUERY) |=> (busy && !done))
        else $error("query did not start a scan");

    // a dropped append never reports a hit
    a_status_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status) |-> (!rsp.hit_obstacle && !rsp.hit_target))
        else $error("status and hit together");

    // a scan ends with a result beat
    a_scan_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("scan ended without result beat");

endmodule

bind rect_table_overlap_query rtoq_checker u_rtoq_checker (.*);

>>> sim/rect_table_overlap_query_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the rectangle table overlap query block

class overlap_scoreboard;
    typedef struct {
        longint x;
        longint y;
        longint w;
        longint h;
    } box_t;

    box_t           obstacle_boxes[rtoq_pkg::OBSTACLE_DEPTH];
    box_t           target_boxes[rtoq_pkg::TARGET_DEPTH];
    int             obstacle_fill;
    int             target_fill;
    rtoq_pkg::rsp_t awaited[$];
    int             mismatches;

    function new();
        obstacle_fill = 0;
        target_fill   = 0;
        mismatches    = 0;
    endfunction

    // low coordinate bits, sign-extended from the top one
    function longint coord_value(longint raw);
        longint v;
        v = raw & ((longint'(1) << rtoq_pkg::COORD_BITS) - 1);
        if (v[rtoq_pkg::COORD_BITS-1])
        begin
            v = v - (longint'(1) << rtoq_pkg::COORD_BITS);
        end
        return v;
    endfunction

    function longint size_value(longint raw);
        return raw & ((longint'(1) << (rtoq_pkg::COORD_BITS - 1)) - 1);
    endfunction

    // strict overlap, touching edges do not count
    function bit boxes_cross(box_t a, box_t b);
        return (a.y + a.h > b.y) && (a.y < b.y + b.h) &&
               (a.x + a.w > b.x) && (a.x < b.x + b.w);
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void note_input(rtoq_pkg::req_t r);
        box_t           b;
        rtoq_pkg::rsp_t e;
        e   = '0;
        b.x = coord_value(longint'(r.pos_x));
        b.y = coord_value(longint'(r.pos_y));
        b.w = size_value(longint'(r.rect_width));
        b.h = size_value(longint'(r.rect_height));
        case (r.cmd)
            rtoq_pkg::CMD_ADD_OBSTACLE:
            begin
                if (obstacle_fill < rtoq_pkg::OBSTACLE_DEPTH)
                begin
                    obstacle_boxes[obstacle_fill] = b;
                    obstacle_fill++;
                end
                else
                begin
                    e.status = 1'b1;
                end
            end
            rtoq_pkg::CMD_ADD_TARGET:
            begin
                if (target_fill < rtoq_pkg::TARGET_DEPTH)
                begin
                    target_boxes[target_fill] = b;
                    target_fill++;
                end
                else
                begin
                    e.status = 1'b1;
                end
            end
            rtoq_pkg::CMD_CLEAR:
            begin
                obstacle_fill = 0;
                target_fill   = 0;
            end
            default:
            begin
                for (int i = 0; i < obstacle_fill; i++)
                begin
                    if (boxes_cross(obstacle_boxes[i], b))
                        e.hit_obstacle = 1'b1;
                end
                for (int i = 0; i < target_fill; i++)
                begin
                    if (boxes_cross(target_boxes[i], b))
                        e.hit_target = 1'b1;
                end
            end
        endcase
        awaited = {awaited, e};
    endfunction

    function void report(string what, rtoq_pkg::rsp_t want, rtoq_pkg::rsp_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected obstacle %b target %b status %b, got %b %b %b",
                     $realtime, what, want.hit_obstacle, want.hit_target, want.status,
                     got.hit_obstacle, got.hit_target, got.status);
        end
    endfunction

    function void check(rtoq_pkg::rsp_t got);
        rtoq_pkg::rsp_t want;
        if (awaited.size() == 0)
        begin
            want = '0;
            report("result with no command outstanding", want, got);
        end
        else
        begin
            want = awaited.pop_front();
            if (got.hit_obstacle !== want.hit_obstacle || got.hit_target !== want.hit_target ||
                got.status !== want.status)
                report("wrong result", want, got);
        end
    endfunction
endclass

module rect_table_overlap_query_test;
    import rtoq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    rsp_t rsp;

    overlap_scoreboard sb;
    int                burst_left;
    int                items_sent;
    int                cycle_count = 0;
    req_t              placed[$];

    rect_table_overlap_query dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rect_table_overlap_query_test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(rsp);
    end

    // one command beat; bursts of random length with random gaps between them
    task automatic send_beat(req_t r);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        sb.note_input(r);
        burst_left--;
        items_sent++;
    endtask

    // hold off until every outstanding result has come back
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic req_t make_req(cmd_t c, int x, int y, int w, int h);
        req_t r;
        r.cmd         = c;
        r.pos_x       = 16'(x);
        r.pos_y       = 16'(y);
        r.rect_width  = 15'(w);
        r.rect_height = 15'(h);
        return r;
    endfunction

    // small rectangle in a crowded window, so queries hit often
    function automatic req_t near_rect(cmd_t c);
        return make_req(c, int'($urandom_range(0, 160)) - 80, int'($urandom_range(0, 160)) - 80,
                        ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40),
                        ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40));
    endfunction

    function automatic req_t wide_rect(cmd_t c);
        req_t r;
        r     = req_t'({$urandom, $urandom});
        r.cmd = c;
        return r;
    endfunction

    // query placed against a stored rectangle: on its edges, inside it, or just over it
    function automatic req_t probe_from(req_t p);
        req_t q;
        q     = p;
        q.cmd = CMD_QUERY;
        case ($urandom_range(0, 5))
            0: ;
            1: q.pos_x = p.pos_x + 16'(p.rect_width);
            2: q.pos_y = p.pos_y + 16'(p.rect_height);
            3:
            begin
                q.rect_width  = 15'($urandom_range(0, 50));
                q.pos_x       = p.pos_x - 16'(q.rect_width);
            end
            4:
            begin
                q.rect_width  = '0;
                q.rect_height = '0;
                q.pos_x       = p.pos_x + 16'($urandom_range(0, p.rect_width));
                q.pos_y       = p.pos_y + 16'($urandom_range(0, p.rect_height));
            end
            default:
            begin
                q.pos_x       = p.pos_x + 16'(p.rect_width) - 16'd1;
                q.rect_width  = 15'd1;
            end
        endcase
        return q;
    endfunction

    task automatic run_directed();
        send_beat(make_req(CMD_CLEAR, 0, 0, 0, 0));
        send_beat(make_req(CMD_QUERY, 0, 0, 5, 5));
        send_beat(make_req(CMD_ADD_OBSTACLE, 0, 0, 10, 10));
        send_beat(make_req(CMD_ADD_TARGET, -32768, -32768, 32767, 32767));
        // shares the obstacle's right edge
        send_beat(make_req(CMD_QUERY, 10, 0, 5, 5));
        // point strictly inside the obstacle
        send_beat(make_req(CMD_QUERY, 9, 9, 0, 0));
        // corner touches both stored rectangles
        send_beat(make_req(CMD_QUERY, -1, -1, 1, 1));
        // edge sums run past the coordinate range
        send_beat(make_req(CMD_ADD_TARGET, 32767, 32767, 32767, 32767));
        send_beat(make_req(CMD_QUERY, 32767, 32767, 1, 1));
        send_beat(make_req(CMD_QUERY, -32768, -32768, 32767, 32767));
        settle();
        for (int i = 0; i < OBSTACLE_DEPTH - 1; i++)
            send_beat(near_rect(CMD_ADD_OBSTACLE));
        // table full: dropped, so the query next to it must miss
        send_beat(make_req(CMD_ADD_OBSTACLE, 20000, 20000, 5, 5));
        send_beat(make_req(CMD_QUERY, 20001, 20001, 1, 1));
        send_beat(make_req(CMD_CLEAR, 0, 0, 0, 0));
        send_beat(make_req(CMD_QUERY, -32768, -32768, 32767, 32767));
    endtask

    // scenes: clear most of the time, fill both tables, then probe them
    task automatic run_random();
        int   stop_at;
        int   n_obstacle;
        int   n_target;
        bit   spread;
        cmd_t c;
        req_t r;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            spread = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 5) != 0)
            begin
                send_beat(wide_rect(CMD_CLEAR));
                placed.delete();
            end
            n_obstacle = $urandom_range(0, OBSTACLE_DEPTH + 2);
            n_target   = $urandom_range(0, TARGET_DEPTH + 2);
            while (n_obstacle + n_target > 0)
            begin
                if (n_target == 0 || (n_obstacle > 0 && $urandom_range(0, 1) == 1))
                begin
                    c = CMD_ADD_OBSTACLE;
                    n_obstacle--;
                end
                else
                begin
                    c = CMD_ADD_TARGET;
                    n_target--;
                end
                r = spread ? wide_rect(c) : near_rect(c);
                placed = {placed, r};
                send_beat(r);
            end
            repeat ($urandom_range(3, 12))
            begin
                case ($urandom_range(0, 9))
                    0:       r = wide_rect(cmd_t'($urandom_range(0, 3)));
                    1, 2:    r = spread ? wide_rect(CMD_QUERY) : near_rect(CMD_QUERY);
                    default: r = (placed.size() != 0)
                                 ? probe_from(placed[$urandom_range(0, placed.size() - 1)])
                                 : near_rect(CMD_QUERY);
                endcase
                send_beat(r);
            end
            if ($urandom_range(0, 4) == 0)
                settle();
        end
    endtask

    initial
    begin
        sb         = new();
        burst_left = 0;
        items_sent = 0;
        start <= 1'b0;
        req   <= '0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        settle();
        run_random();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("rect_table_overlap_query_test passed");
        else
            $display("rect_table_overlap_query_test failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/rtoq_pkg.sv
rtl/core/rtoq_ram.sv
rtl/core/rect_table_overlap_query.sv
rtl/core/rtoq_checker.sv
sim/rect_table_overlap_query_test.sv
